FILE: rtl/core/dff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance falloff force field: shared package
// Widths, step counts, register indexes and the stage sideband structs.
// ----------------------------------------------------------------------------
package dff_pkg;

  localparam int PosW     = 32;
  localparam int ForceW   = 25;
  localparam int RadW     = 31;
  localparam int GainW    = 16;
  localparam int QuoW     = 33;   // falloff ratio quotient, one bit per step
  localparam int RootW    = 32;   // square root steps
  localparam int NumW     = 56;   // component dividend, one bit per step
  localparam int MagW     = 24;   // Q16.8 magnitude

  localparam logic [RadW-1:0] FallbackStep = 31'd26;

  typedef enum logic [1:0] {
    CFG_MIN_DISTANCE = 2'd0,
    CFG_MAX_DISTANCE = 2'd1,
    CFG_FORCE_GAIN   = 2'd2,
    CFG_REPEL_MODE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                   far;
    logic                   near;
    logic                   inrange;
    logic [GainW-1:0]       gain;
    logic [2:0]             neg;
    logic [2:0][PosW-1:0]   mag;
  } qside_t;

  typedef struct packed {
    logic       zero;
    logic       apply;
    logic [2:0] neg;
  } cside_t;

endpackage

FILE: rtl/core/dff_qroot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Falloff ratio divider and distance root
// One restoring quotient bit per stage, and one square root step in each of the first RootW stages.
// ----------------------------------------------------------------------------
module dff_qroot (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [127:0]                 num,
  input  logic [127:0]                 den,
  input  logic [63:0]                  rad,
  input  dff_pkg::qside_t              in_side,
  output logic                         out_valid,
  output logic [dff_pkg::QuoW-1:0]     quo,
  output logic [dff_pkg::RootW-1:0]    root,
  output dff_pkg::qside_t              out_side
);

  localparam int N = dff_pkg::QuoW;

  logic [N-1:0]                vld;
  logic [127:0]                rem  [N];
  logic [127:0]                dv   [N];
  logic [dff_pkg::QuoW-1:0]    qq   [N];
  logic [63:0]                 rn   [N];
  logic [63:0]                 rr   [N];
  dff_pkg::qside_t             sd   [N];

  genvar g;
  for (g = 0; g < N; g++) begin : g_step
    logic                      v_in;
    logic [127:0]              rem_in;
    logic [127:0]              den_in;
    logic [dff_pkg::QuoW-1:0]  q_in;
    logic [63:0]               n_in;
    logic [63:0]               res_in;
    dff_pkg::qside_t           side_in;
    logic [128:0]              trial;
    logic [128:0]              diff;
    logic                      ge;
    logic [127:0]              rem_next;
    logic [63:0]               n_next;
    logic [63:0]               res_next;

    if (g == 0) begin : g_head
      assign v_in    = in_valid;
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign n_in    = rad;
      assign res_in  = '0;
      assign side_in = in_side;
      assign trial   = {1'b0, rem_in};
    end else begin : g_tail
      assign v_in    = vld[g-1];
      assign rem_in  = rem[g-1];
      assign den_in  = dv[g-1];
      assign q_in    = qq[g-1];
      assign n_in    = rn[g-1];
      assign res_in  = rr[g-1];
      assign side_in = sd[g-1];
      assign trial   = {rem_in, 1'b0};
    end

    assign diff     = trial - {1'b0, den_in};
    assign ge       = trial >= {1'b0, den_in};
    assign rem_next = ge ? diff[127:0] : trial[127:0];

    if (g < dff_pkg::RootW) begin : g_root
      localparam logic [63:0] Bit = 64'd1 << (62 - 2 * g);
      logic [63:0] cand;
      logic        take;
      assign cand     = res_in + Bit;
      assign take     = n_in >= cand;
      assign n_next   = take ? n_in - cand : n_in;
      assign res_next = take ? (res_in >> 1) + Bit : res_in >> 1;
    end else begin : g_pass
      assign n_next   = n_in;
      assign res_next = res_in;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g] <= rem_next;
        dv[g]  <= den_in;
        qq[g]  <= {q_in[dff_pkg::QuoW-2:0], ge};
        rn[g]  <= n_next;
        rr[g]  <= res_next;
        sd[g]  <= side_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = qq[N-1];
  assign root      = rr[N-1][dff_pkg::RootW-1:0];
  assign out_side  = sd[N-1];

endmodule

FILE: rtl/core/dff_cdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Force component divider
// Three lanes of restoring division, one dividend bit per stage.
// ----------------------------------------------------------------------------
module dff_cdiv (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][dff_pkg::NumW-1:0]         num,
  input  logic [dff_pkg::RootW-1:0]             den,
  input  dff_pkg::cside_t                       in_side,
  output logic                                  out_valid,
  output logic [2:0][dff_pkg::ForceW-1:0]       quo,
  output dff_pkg::cside_t                       out_side
);

  localparam int N  = dff_pkg::NumW;
  localparam int DW = dff_pkg::RootW;
  localparam int QW = dff_pkg::ForceW;

  logic [N-1:0]                vld;
  logic [2:0][N-1:0]           nn [N];
  logic [2:0][DW-1:0]          rm [N];
  logic [2:0][QW-1:0]          qq [N];
  logic [DW-1:0]               dv [N];
  dff_pkg::cside_t             sd [N];

  genvar g;
  for (g = 0; g < N; g++) begin : g_step
    logic                  v_in;
    logic [2:0][N-1:0]     n_in;
    logic [2:0][DW-1:0]    r_in;
    logic [2:0][QW-1:0]    q_in;
    logic [DW-1:0]         d_in;
    dff_pkg::cside_t       side_in;
    logic [2:0][DW:0]      tw;
    logic [2:0][DW:0]      df;
    logic [2:0]            ge;
    logic [2:0][N-1:0]     n_next;
    logic [2:0][DW-1:0]    r_next;
    logic [2:0][QW-1:0]    q_next;

    if (g == 0) begin : g_head
      assign v_in    = in_valid;
      assign n_in    = num;
      assign r_in    = '0;
      assign q_in    = '0;
      assign d_in    = den;
      assign side_in = in_side;
    end else begin : g_tail
      assign v_in    = vld[g-1];
      assign n_in    = nn[g-1];
      assign r_in    = rm[g-1];
      assign q_in    = qq[g-1];
      assign d_in    = dv[g-1];
      assign side_in = sd[g-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        tw[l]     = {r_in[l], n_in[l][N-1]};
        df[l]     = tw[l] - {1'b0, d_in};
        ge[l]     = tw[l] >= {1'b0, d_in};
        r_next[l] = ge[l] ? df[l][DW-1:0] : tw[l][DW-1:0];
        n_next[l] = {n_in[l][N-2:0], 1'b0};
        q_next[l] = {q_in[l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nn[g] <= n_next;
        rm[g] <= r_next;
        qq[g] <= q_next;
        dv[g] <= d_in;
        sd[g] <= side_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = qq[N-1];
  assign out_side  = sd[N-1];

endmodule

FILE: rtl/core/distance_falloff_force_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance falloff force field
// Force on an object from a source, scaled by an inverse-square falloff.
// ----------------------------------------------------------------------------
// Input beats carry a source and an object position (signed Q23.8); each
// beat gives one output beat with the Q16.8 force vector in tdata and the
// apply flag in tuser. The four registers are written through cfg_we,
// cfg_addr and cfg_wdata only while no beat is in flight, a rule that the
// user keeps and the block does not enforce. Throughput is one beat per
// clock unless the output is held. Beats pass the 33 stage ratio divider
// (the distance root runs beside it) and the 56 stage component divider.
// The whole pipeline advances together; when the output beat is held by
// tready low every stage holds, and s_axis_tready drops until it is taken.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: inner radius 26, outer radius 52, gain 0, attract mode.
// ----------------------------------------------------------------------------
module distance_falloff_force_field (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // src_x, src_y, src_z, obj_x, obj_y, obj_z
  input  logic [191:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // force_x, force_y, force_z, zero pad
  output logic [79:0]   m_axis_tdata,
  // apply
  output logic          m_axis_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [30:0]   cfg_wdata
);

  localparam int PW = dff_pkg::PosW;
  localparam int FW = dff_pkg::ForceW;

  logic [dff_pkg::RadW-1:0]  min_distance;
  logic [dff_pkg::RadW-1:0]  max_distance;
  logic [dff_pkg::GainW-1:0] force_gain;
  logic                      repel_mode;
  logic [dff_pkg::RadW-1:0]  mn_next;
  logic [PW-1:0]             mx_next;
  logic [dff_pkg::RadW-1:0]  mn;
  logic [PW-1:0]             mx;
  logic                      en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= 31'd26;
      max_distance <= 31'd52;
      force_gain   <= '0;
      repel_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (dff_pkg::cfg_idx_t'(cfg_addr))
        dff_pkg::CFG_MIN_DISTANCE: min_distance <= cfg_wdata;
        dff_pkg::CFG_MAX_DISTANCE: max_distance <= cfg_wdata;
        dff_pkg::CFG_FORCE_GAIN:   force_gain   <= cfg_wdata[dff_pkg::GainW-1:0];
        dff_pkg::CFG_REPEL_MODE:   repel_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sanitize radii
  always_comb begin
    mn_next = (min_distance == '0) ? dff_pkg::FallbackStep : min_distance;
    mx_next = ({1'b0, max_distance} <= {1'b0, mn_next}) ?
              {1'b0, mn_next} + {1'b0, dff_pkg::FallbackStep} : {1'b0, max_distance};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mn <= 31'd26;
      mx <= 32'd52;
    end else begin
      mn <= mn_next;
      mx <= mx_next;
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: differences and magnitudes
  logic [2:0][PW:0]          dlt;
  logic [2:0][PW:0]          mg;
  logic                      far_c;

  always_comb begin
    far_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dlt[i] = repel_mode ?
               {s_axis_tdata[PW*(i+3)+PW-1], s_axis_tdata[PW*(i+3) +: PW]} -
               {s_axis_tdata[PW*i+PW-1], s_axis_tdata[PW*i +: PW]} :
               {s_axis_tdata[PW*i+PW-1], s_axis_tdata[PW*i +: PW]} -
               {s_axis_tdata[PW*(i+3)+PW-1], s_axis_tdata[PW*(i+3) +: PW]};
      mg[i]  = dlt[i][PW] ? (33'd0 - dlt[i]) : dlt[i];
      if (mg[i] > {1'b0, mx}) begin
        far_c = 1'b1;
      end
    end
  end

  logic                      v0;
  logic [2:0][PW-1:0]        s0_mag;
  logic [2:0]                s0_neg;
  logic                      s0_far;
  logic [dff_pkg::RadW-1:0]  s0_mn;
  logic [PW-1:0]             s0_mx;
  logic [dff_pkg::GainW-1:0] s0_gain;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_mag[i] <= mg[i][PW-1:0];
        s0_neg[i] <= dlt[i][PW];
      end
      s0_far  <= far_c;
      s0_mn   <= mn;
      s0_mx   <= mx;
      s0_gain <= force_gain;
    end
  end

  // stage 1: squares
  logic                      v1;
  logic [2:0][63:0]          s1_sq;
  logic [61:0]               s1_mn2;
  logic [63:0]               s1_mx2;
  logic [2:0][PW-1:0]        s1_mag;
  logic [2:0]                s1_neg;
  logic                      s1_far;
  logic [dff_pkg::GainW-1:0] s1_gain;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= 64'(s0_mag[i]) * 64'(s0_mag[i]);
      end
      s1_mn2  <= 62'(s0_mn) * 62'(s0_mn);
      s1_mx2  <= 64'(s0_mx) * 64'(s0_mx);
      s1_mag  <= s0_mag;
      s1_neg  <= s0_neg;
      s1_far  <= s0_far;
      s1_gain <= s0_gain;
    end
  end

  // stage 2: squared distance
  logic                      v2;
  logic [63:0]               s2_d2;
  logic [61:0]               s2_mn2;
  logic [63:0]               s2_mx2;
  logic [63:0]               s2_span;
  logic [2:0][PW-1:0]        s2_mag;
  logic [2:0]                s2_neg;
  logic                      s2_far;
  logic [dff_pkg::GainW-1:0] s2_gain;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d2   <= s1_sq[0] + s1_sq[1] + s1_sq[2];
      s2_mn2  <= s1_mn2;
      s2_mx2  <= s1_mx2;
      s2_span <= s1_mx2 - {2'b0, s1_mn2};
      s2_mag  <= s1_mag;
      s2_neg  <= s1_neg;
      s2_far  <= s1_far;
      s2_gain <= s1_gain;
    end
  end

  // stage 3: region
  logic                      v3;
  logic [63:0]               s3_d2;
  logic [61:0]               s3_mn2;
  logic [63:0]               s3_span;
  logic [63:0]               s3_gap;
  dff_pkg::qside_t           s3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d2           <= s2_d2;
      s3_mn2          <= s2_mn2;
      s3_span         <= s2_span;
      s3_gap          <= s2_mx2 - s2_d2;
      s3_side.far     <= s2_far;
      s3_side.near    <= s2_d2 < {2'b0, s2_mn2};
      s3_side.inrange <= s2_d2 <= s2_mx2;
      s3_side.gain    <= s2_gain;
      s3_side.neg     <= s2_neg;
      s3_side.mag     <= s2_mag;
    end
  end

  // stage 4: partial products of num = mn2 * gap, den = d2 * span
  logic                      v4;
  logic [3:0][63:0]          s4_pa;
  logic [3:0][63:0]          s4_pb;
  logic [63:0]               s4_d2;
  dff_pkg::qside_t           s4_side;
  logic [63:0]               mn2_w;

  assign mn2_w = {2'b0, s3_mn2};

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pa[0] <= 64'(mn2_w[31:0])  * 64'(s3_gap[31:0]);
      s4_pa[1] <= 64'(mn2_w[31:0])  * 64'(s3_gap[63:32]);
      s4_pa[2] <= 64'(mn2_w[63:32]) * 64'(s3_gap[31:0]);
      s4_pa[3] <= 64'(mn2_w[63:32]) * 64'(s3_gap[63:32]);
      s4_pb[0] <= 64'(s3_d2[31:0])  * 64'(s3_span[31:0]);
      s4_pb[1] <= 64'(s3_d2[31:0])  * 64'(s3_span[63:32]);
      s4_pb[2] <= 64'(s3_d2[63:32]) * 64'(s3_span[31:0]);
      s4_pb[3] <= 64'(s3_d2[63:32]) * 64'(s3_span[63:32]);
      s4_d2    <= s3_d2;
      s4_side  <= s3_side;
    end
  end

  // stage 5: middle sums
  logic                      v5;
  logic [127:0]              s5_ba;
  logic [127:0]              s5_bb;
  logic [64:0]               s5_ma;
  logic [64:0]               s5_mb;
  logic [63:0]               s5_d2;
  dff_pkg::qside_t           s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ba   <= {s4_pa[3], s4_pa[0]};
      s5_bb   <= {s4_pb[3], s4_pb[0]};
      s5_ma   <= {1'b0, s4_pa[1]} + {1'b0, s4_pa[2]};
      s5_mb   <= {1'b0, s4_pb[1]} + {1'b0, s4_pb[2]};
      s5_d2   <= s4_d2;
      s5_side <= s4_side;
    end
  end

  // stage 6: full products
  logic                      v6;
  logic [127:0]              s6_num;
  logic [127:0]              s6_den;
  logic [63:0]               s6_d2;
  dff_pkg::qside_t           s6_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_num  <= s5_ba + {31'd0, s5_ma, 32'd0};
      s6_den  <= s5_bb + {31'd0, s5_mb, 32'd0};
      s6_d2   <= s5_d2;
      s6_side <= s5_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  logic                          qr_valid;
  logic [dff_pkg::QuoW-1:0]      qr_quo;
  logic [dff_pkg::RootW-1:0]     qr_root;
  dff_pkg::qside_t               qr_side;

  dff_qroot u_qroot (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .num      (s6_num),
    .den      (s6_den),
    .rad      (s6_d2),
    .in_side  (s6_side),
    .out_valid(qr_valid),
    .quo      (qr_quo),
    .root     (qr_root),
    .out_side (qr_side)
  );

  // magnitude: scale ratio by gain
  logic                          vm1;
  logic [dff_pkg::MagW-1:0]      m1_ratio;
  logic [dff_pkg::RootW-1:0]     m1_root;
  dff_pkg::qside_t               m1_side;
  logic [48:0]                   gq;

  assign gq = 49'(qr_side.gain) * 49'(qr_quo);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ratio <= gq[47:24];
      m1_root  <= qr_root;
      m1_side  <= qr_side;
    end
  end

  logic [dff_pkg::MagW-1:0]      mag_sel;
  logic                          vm2;
  logic [2:0][dff_pkg::NumW-1:0] m2_num;
  logic [dff_pkg::RootW-1:0]     m2_root;
  dff_pkg::cside_t               m2_side;

  always_comb begin
    if (m1_side.far) begin
      mag_sel = '0;
    end else if (m1_side.near) begin
      mag_sel = {m1_side.gain, 8'd0};
    end else if (m1_side.inrange) begin
      mag_sel = m1_ratio;
    end else begin
      mag_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m2_num[i] <= 56'(m1_side.mag[i]) * 56'(mag_sel);
      end
      m2_root       <= m1_root;
      m2_side.zero  <= (mag_sel == '0) || (m1_root == '0);
      m2_side.apply <= mag_sel != '0;
      m2_side.neg   <= m1_side.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
    end else if (en) begin
      vm1 <= qr_valid;
      vm2 <= vm1;
    end
  end

  logic                          cd_valid;
  logic [2:0][FW-1:0]            cd_quo;
  dff_pkg::cside_t               cd_side;

  dff_cdiv u_cdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vm2),
    .num      (m2_num),
    .den      (m2_root),
    .in_side  (m2_side),
    .out_valid(cd_valid),
    .quo      (cd_quo),
    .out_side (cd_side)
  );

  // output register: apply signs
  logic [2:0][FW-1:0]            fc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cd_side.zero) begin
        fc[i] = '0;
      end else if (cd_side.neg[i]) begin
        fc[i] = '0 - cd_quo[i];
      end else begin
        fc[i] = cd_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {5'd0, fc[2], fc[1], fc[0]};
      m_axis_tuser <= cd_side.apply;
    end
  end

endmodule

FILE: rtl/core/dff_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance falloff force field: port checker
// Output handshake and result sanity seen at the top level ports.
// ----------------------------------------------------------------------------
module dff_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [79:0]  m_axis_tdata,
  input logic         m_axis_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_no_force: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("force present without apply");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind distance_falloff_force_field dff_checker u_dff_checker (.*);

FILE: dv/tb_distance_falloff_force_field.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance falloff force field: testbench
// Directed table of positions and register settings, then random source and
// object pairs spread around the inner and outer radii, each checked against
// an in-bench falloff predictor under random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_distance_falloff_force_field;

  typedef struct {
    logic [24:0] fx;
    logic [24:0] fy;
    logic [24:0] fz;
    logic        apply;
  } force_t;

  typedef struct {
    int          phase;
    logic [31:0] p [6];
    bit          known;
    force_t      want;
  } row_t;

  logic          clk;
  logic          rst;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [191:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [79:0]   m_axis_tdata;
  logic          m_axis_tuser;
  logic          cfg_we;
  logic [1:0]    cfg_addr;
  logic [30:0]   cfg_wdata;

  distance_falloff_force_field uut (.*);

  logic [30:0] rad_min, rad_max;
  logic [15:0] gain;
  logic        repel;

  force_t      pending_forces [$];
  int          errors, beats_in, beats_out, nonzero_out, idle_cycles;
  bit          calm, hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic force_t falloff_force(logic [191:0] pos);
    longint signed   dl [3];
    longint unsigned mg [3];
    longint unsigned mn, mx, mn2, mx2, d2, m, d, v;
    logic [191:0]    a, b, q;
    bit              far;
    logic [24:0]     f [3];
    force_t          r;
    mn = (rad_min == 0) ? 64'd26 : 64'(rad_min);
    mx = 64'(rad_max);
    if (mx <= mn) mx = mn + 26;
    mn2 = mn * mn;
    mx2 = mx * mx;
    far = 0;
    d2 = 0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = repel ? longint'(signed'(pos[32*(i+3) +: 32])) - longint'(signed'(pos[32*i +: 32]))
                    : longint'(signed'(pos[32*i +: 32])) - longint'(signed'(pos[32*(i+3) +: 32]));
      mg[i] = (dl[i] < 0) ? longint'(-dl[i]) : dl[i];
      if (mg[i] > mx) far = 1;
    end
    if (!far) begin
      for (int i = 0; i < 3; i++) d2 += mg[i] * mg[i];
      if (d2 < mn2) begin
        m = 64'(gain) << 8;
      end else if (d2 <= mx2) begin
        a = (192'(mn2) * 192'(mx2 - d2)) << 32;
        b = 192'(d2) * 192'(mx2 - mn2);
        q = a / b;
        m = (64'(gain) * q[63:0]) >> 24;
      end
    end
    d = far ? 0 : root_floor(d2);
    for (int i = 0; i < 3; i++) begin
      f[i] = '0;
      if (m != 0 && d != 0) begin
        v = mg[i] * m / d;
        f[i] = (dl[i] < 0) ? 25'(-v) : 25'(v);
      end
    end
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    r.apply = (m > 0);
    return r;
  endfunction

  task automatic write_reg(dff_pkg::cfg_idx_t idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      dff_pkg::CFG_MIN_DISTANCE: rad_min = val;
      dff_pkg::CFG_MAX_DISTANCE: rad_max = val;
      dff_pkg::CFG_FORCE_GAIN:   gain    = val[15:0];
      dff_pkg::CFG_REPEL_MODE:   repel   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_field(logic [30:0] mn, logic [30:0] mx, logic [30:0] g, bit rp);
    write_reg(dff_pkg::CFG_MIN_DISTANCE, mn);
    write_reg(dff_pkg::CFG_MAX_DISTANCE, mx);
    write_reg(dff_pkg::CFG_FORCE_GAIN, g);
    write_reg(dff_pkg::CFG_REPEL_MODE, {30'd0, rp});
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_forces.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (110) @(posedge clk);
  endtask

  // hold the beat until taken; lower tvalid only ahead of a gap
  task automatic send_beat(logic [191:0] data, bit known, force_t want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    pending_forces.push_back(known ? want : falloff_force(data));
    beats_in++;
  endtask

  task automatic finish_beats();
    s_axis_tvalid <= 1'b0;
  endtask

  // output side: random stalls plus one long hold once the pipe is busy
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 0;
    @(negedge rst);
    forever begin
      if (!hold_done && beats_in > 200) begin
        hold_done = 1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    force_t exp_f;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_out <= beats_out + 1;
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected beat tdata=%h tuser=%b", $time, m_axis_tdata,
                 m_axis_tuser);
        errors <= errors + 1;
      end else begin
        exp_f = pending_forces.pop_front();
        if (exp_f.apply) nonzero_out <= nonzero_out + 1;
        if (m_axis_tdata[24:0] !== exp_f.fx || m_axis_tdata[49:25] !== exp_f.fy ||
            m_axis_tdata[74:50] !== exp_f.fz || m_axis_tdata[79:75] !== 5'd0 ||
            m_axis_tuser !== exp_f.apply) begin
          $display("%0t: mismatch expected fx=%h fy=%h fz=%h apply=%b", $time,
                   exp_f.fx, exp_f.fy, exp_f.fz, exp_f.apply);
          $display("%0t:          actual   fx=%h fy=%h fz=%h apply=%b pad=%h", $time,
                   m_axis_tdata[24:0], m_axis_tdata[49:25], m_axis_tdata[74:50],
                   m_axis_tuser, m_axis_tdata[79:75]);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("%0t: watchdog expired, %0d beats outstanding", $time,
               pending_forces.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [191:0] pack_pos(logic [31:0] p [6]);
    logic [191:0] r;
    for (int i = 0; i < 6; i++) r[32*i +: 32] = p[i];
    return r;
  endfunction

  function automatic logic [31:0] near_offset(longint unsigned span);
    longint unsigned u;
    u = {$urandom, $urandom} % (2 * span + 1);
    return 32'(longint'(u) - longint'(span));
  endfunction

  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;
  localparam force_t FZERO = '{25'd0, 25'd0, 25'd0, 1'b0};
  localparam force_t FZERO_APPLY = '{25'd0, 25'd0, 25'd0, 1'b1};

  row_t plan [$];

  task automatic add_row(int ph, logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                         logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
                         bit known, force_t want);
    row_t r;
    r.phase = ph;
    r.p = '{a0, a1, a2, b0, b1, b2};
    r.known = known;
    r.want = want;
    plan.push_back(r);
  endtask

  initial begin
    logic [31:0]     pos [6];
    longint unsigned span, mxe;
    int              cur, sel;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    nonzero_out = 0;
    calm = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = dff_pkg::CFG_MIN_DISTANCE;
    cfg_wdata = '0;
    rad_min = 31'd26;
    rad_max = 31'd52;
    gain = 16'd0;
    repel = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: zero gain gives a zero force everywhere
    add_row(0, 0, 0, 0, 0, 0, 0, 1, FZERO);
    add_row(0, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1, FZERO);
    add_row(0, 10, -5, 3, 0, 0, 0, 1, FZERO);
    // full gain, zero radii fall back to 26 and 52
    add_row(1, 0, 0, 0, 0, 0, 0, 1, FZERO_APPLY);
    add_row(1, 100, 200, 300, 100, 200, 300, 1, FZERO_APPLY);
    add_row(1, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1, FZERO);
    add_row(1, PMIN, 0, 0, PMAX, 0, 0, 1, FZERO);
    add_row(1, 10, 0, 0, 0, 0, 0, 0, FZERO);
    add_row(1, 30, 0, 0, 0, 0, 0, 0, FZERO);
    add_row(1, 0, -40, 0, 0, 0, 0, 0, FZERO);
    add_row(1, 20, 20, 20, 0, 0, 0, 0, FZERO);
    add_row(1, 52, 0, 0, 0, 0, 0, 0, FZERO);
    add_row(1, 53, 0, 0, 0, 0, 0, 1, FZERO);
    // repel, inner radius at the top of its range
    add_row(2, 0, 0, 0, 1000, -2000, 3000, 0, FZERO);
    add_row(2, PMAX, PMIN, 0, PMIN, PMAX, 0, 0, FZERO);
    add_row(2, 0, 0, 0, 0, 0, 0, 1, FZERO_APPLY);
    // max radius not above min, small gain
    add_row(3, 0, 0, 0, 300, 0, 0, 0, FZERO);
    add_row(3, 0, 0, 0, 260, 10, -10, 0, FZERO);
    add_row(3, 0, 0, 0, -270, 0, 5, 0, FZERO);
    add_row(3, 0, 0, 0, 0, 255, 0, 0, FZERO);

    cur = 0;
    foreach (plan[k]) begin
      if (plan[k].phase != cur) begin
        finish_beats();
        drain();
        cur = plan[k].phase;
        case (cur)
          1: set_field(31'd0, 31'd0, 31'h7FFF_FFFF, 1'b0);
          2: set_field(31'h7FFF_FFFF, 31'd0, 31'd1, 1'b1);
          3: set_field(31'd256, 31'd200, 31'd777, 1'b0);
          default: ;
        endcase
      end
      send_beat(pack_pos(plan[k].p), plan[k].known, plan[k].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      finish_beats();
      drain();
      case (ph)
        0: set_field(31'd256, 31'd2560, 31'd65535, 1'b0);
        1: set_field(31'd1, 31'd3, 31'd40000, 1'b1);
        2: set_field(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd65535, 1'b0);
        3: set_field(31'd0, 31'h7FFF_FFFF, 31'd1234, 1'b1);
        default: set_field($urandom_range(0, 1) ? 31'($urandom_range(0, 5000)) : 31'($urandom),
                           $urandom_range(0, 1) ? 31'($urandom_range(0, 50000)) : 31'($urandom),
                           31'($urandom), $urandom_range(0, 1));
      endcase
      calm = (ph == 7);
      mxe = (rad_min == 0) ? 26 : rad_min;
      mxe = (rad_max <= mxe) ? mxe + 26 : rad_max;
      for (int n = 0; n < 170; n++) begin
        sel = $urandom_range(0, 19);
        for (int i = 0; i < 3; i++) pos[i] = $urandom;
        span = (sel < 8) ? mxe : (sel < 14) ? mxe * 3 / 4 : (sel < 17) ? mxe / 3 + 1 : 0;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        for (int i = 0; i < 3; i++)
          pos[i + 3] = (sel < 17) ? pos[i] + near_offset(span) : $urandom;
        if (sel == 19) for (int i = 0; i < 6; i++) pos[i] = $urandom_range(0, 1) ? PMAX : PMIN;
        send_beat(pack_pos(pos), 0, FZERO);
      end
    end
    finish_beats();
    drain();

    $display("Covered %0d input beats and %0d output beats, %0d with force applied,",
             beats_in, beats_out, nonzero_out);
    $display("across 12 register settings with random idling and one long output hold.");
    if (errors == 0 && pending_forces.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d beats never returned", errors, pending_forces.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
